// ===== hw/rtl/fir_dt_pkg.sv =====
package fir_dt_pkg;

  localparam int MAX_ORDER_DEF = 31;

  localparam int ORDER_W  = 5;
  localparam int IDX_W    = 5;
  localparam int COEF_W   = 16;
  localparam int SAMP_W   = 16;
  localparam int DLY_W    = 40;
  localparam int PROD_W   = COEF_W + DLY_W;
  // up to 32 products of PROD_W bits, plus margin
  localparam int ACC_W    = PROD_W + 6;
  localparam int FRAC_W   = 14;
  localparam int ROUND_C  = 1 << (FRAC_W - 1);
  localparam int OUT_MAX  = 32767;
  localparam int OUT_MIN  = -32768;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ORDER_W;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_XPOSE = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  // one tap step as it travels down the multiply-accumulate pipeline
  typedef struct packed {
    logic vld;
    logic first;   // tap 0: starts the accumulator
    logic last;    // tap n: ends the item
    logic dly_rd;  // delay read data takes part
    logic xpose;   // transposed form
  } step_t;

endpackage

// ===== hw/rtl/fir_dt_ram.sv =====
module fir_dt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fir_dt_ctrl.sv =====
module fir_dt_ctrl #(
  parameter int MAX_ORDER = fir_dt_pkg::MAX_ORDER_DEF,
  parameter int CAW       = $clog2(MAX_ORDER + 1),
  parameter int DAW       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                cmd_i,
  input  logic signed [fir_dt_pkg::SAMP_W-1:0] sample_i,
  input  logic [fir_dt_pkg::ORDER_W-1:0]      order_i,
  input  logic                                xpose_i,
  input  logic                                done_i,
  input  logic                                out_free_i,
  output logic                                in_stall_o,
  output fir_dt_pkg::step_t                   step_o,
  output logic [CAW-1:0]                      coef_ra_o,
  output logic [DAW-1:0]                      dly_ra_o,
  output logic [DAW-1:0]                      dly_wa_o,
  output logic signed [fir_dt_pkg::SAMP_W-1:0] x_o,
  output logic                                ld_o
);

  import fir_dt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_LOAD
  } state_e;

  state_e                    state_q;
  logic [CAW-1:0]            k_q;
  logic [CAW-1:0]            n_q;
  logic signed [SAMP_W-1:0]  x_q;
  logic                      xpose_q;
  logic [CAW-1:0]            n_eff;
  logic                      running;

  // saturate the order to the store depth
  assign n_eff = (order_i > MAX_ORDER) ? CAW'(MAX_ORDER) : CAW'(order_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      x_q     <= '0;
      xpose_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (cmd_i == CMD_FILTER)) begin
            state_q <= ST_RUN;
            k_q     <= '0;
            n_q     <= n_eff;
            x_q     <= sample_i;
            xpose_q <= xpose_i;
          end
        end
        ST_RUN: begin
          if (k_q == n_q) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (done_i) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign running    = (state_q == ST_RUN);
  assign in_stall_o = (state_q != ST_IDLE);
  assign ld_o       = (state_q == ST_LOAD) && out_free_i;
  assign x_o        = x_q;

  always_comb begin
    step_o.vld    = running;
    step_o.first  = (k_q == '0);
    step_o.last   = (k_q == n_q);
    step_o.xpose  = xpose_q;
    // direct form reads the tap behind, transposed reads the tap ahead
    step_o.dly_rd = xpose_q ? (k_q < n_q) : (k_q != '0);
    coef_ra_o     = k_q;
    dly_wa_o      = DAW'(k_q - 1'b1);
    if (!step_o.dly_rd) begin
      dly_ra_o = '0;
    end else if (xpose_q) begin
      dly_ra_o = DAW'(k_q);
    end else begin
      dly_ra_o = DAW'(k_q - 1'b1);
    end
  end

endmodule

// ===== hw/rtl/fir_dt_mac.sv =====
module fir_dt_mac #(
  parameter int MAX_ORDER = fir_dt_pkg::MAX_ORDER_DEF,
  parameter int DAW       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fir_dt_pkg::step_t                    step_i,
  input  logic [DAW-1:0]                       dly_wa_i,
  input  logic signed [fir_dt_pkg::SAMP_W-1:0] x_i,
  input  logic signed [fir_dt_pkg::COEF_W-1:0] coef_i,
  input  logic signed [fir_dt_pkg::DLY_W-1:0]  dly_i,
  output logic                                 dly_we_o,
  output logic [DAW-1:0]                       dly_wa_o,
  output logic [fir_dt_pkg::DLY_W-1:0]         dly_wd_o,
  output logic                                 done_o,
  output logic signed [fir_dt_pkg::SAMP_W-1:0] y_o,
  output logic                                 clip_o
);

  import fir_dt_pkg::*;

  step_t                    s_b_q, s_c_q;
  logic [DAW-1:0]           wa_b_q, wa_c_q;
  logic signed [DLY_W-1:0]  d_b, d_c_q;
  logic signed [DLY_W-1:0]  opnd;
  logic signed [PROD_W-1:0] prod, prod_c_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DLY_W-1:0]  prev_q;
  logic                     done_q;
  logic signed [ACC_W-1:0]  rnd;

  // stage B: RAM data is out, form the product
  assign d_b  = s_b_q.dly_rd ? dly_i : '0;
  assign opnd = (!s_b_q.xpose && !s_b_q.first) ? d_b : DLY_W'(x_i);
  assign prod = coef_i * opnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_b_q  <= '0;
      s_c_q  <= '0;
      done_q <= 1'b0;
    end else begin
      s_b_q  <= step_i;
      s_c_q  <= s_b_q;
      done_q <= s_c_q.vld && s_c_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_b_q   <= dly_wa_i;
    wa_c_q   <= wa_b_q;
    d_c_q    <= d_b;
    prod_c_q <= prod;
    acc_q    <= acc_d;
    if (s_c_q.vld) begin
      if (s_c_q.first) begin
        prev_q <= DLY_W'(x_i);
      end else if (!s_c_q.xpose) begin
        prev_q <= d_c_q;
      end
    end
  end

  // stage C: accumulate and write the delay entry back
  always_comb begin
    acc_d = acc_q;
    if (s_c_q.vld) begin
      if (s_c_q.first) begin
        acc_d = ACC_W'(prod_c_q) + ACC_W'(d_c_q);
      end else if (!s_c_q.xpose) begin
        acc_d = acc_q + ACC_W'(prod_c_q);
      end
    end
  end

  assign dly_we_o = s_c_q.vld && !s_c_q.first;
  assign dly_wa_o = wa_c_q;
  assign dly_wd_o = s_c_q.xpose ? (d_c_q + prod_c_q[DLY_W-1:0]) : prev_q;
  assign done_o   = done_q;

  // round half-up, drop the fraction, saturate
  assign rnd = (acc_q + ACC_W'(ROUND_C)) >>> FRAC_W;

  always_comb begin
    if (rnd > ACC_W'(OUT_MAX)) begin
      y_o    = SAMP_W'(OUT_MAX);
      clip_o = 1'b1;
    end else if (rnd < ACC_W'(OUT_MIN)) begin
      y_o    = SAMP_W'(OUT_MIN);
      clip_o = 1'b1;
    end else begin
      y_o    = rnd[SAMP_W-1:0];
      clip_o = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/fir_filter_direct_transposed.sv =====
// FIR filter of programmable order, direct or transposed form.
// Input channel (in_valid_i / in_stall_o): each transfer either loads one
// Q2.14 coefficient (cmd 0) or filters one signed 16-bit sample (cmd 1).
// A coefficient load gives no result. A sample gives one
// result on the output channel (out_valid_o / out_stall_i): out_sample_o,
// rounded half-up and saturated, with clipped_o set on saturation.
// A sample runs over taps 0 to n, n being the order (at most MAX_ORDER);
// one multiply-accumulate and one delay memory port handle one tap per
// cycle. The input stalls while a sample is in work.
// The result waits in an output register; the next item is taken while it
// waits, but a finished sample holds until the register frees.
// Configuration: cfg_we_i writes register cfg_idx_i (0 = order, 1 = form);
// the user must write it only while the block is idle; the block itself
// does not enforce this. Writing the order clears the delay line.
// Reset clears coefficients, the delay line and both registers.
module fir_filter_direct_transposed #(
  parameter int MAX_ORDER = fir_dt_pkg::MAX_ORDER_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [fir_dt_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fir_dt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    cmd_i,
  input  logic [fir_dt_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [fir_dt_pkg::COEF_W-1:0]    coef_value_i,
  input  logic signed [fir_dt_pkg::SAMP_W-1:0]    sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [fir_dt_pkg::SAMP_W-1:0]    out_sample_o,
  output logic                                    clipped_o
);

  import fir_dt_pkg::*;

  localparam int CAW = $clog2(MAX_ORDER + 1);
  localparam int DAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [ORDER_W-1:0]       order_q;
  logic                     xpose_q;
  logic [MAX_ORDER:0]       coef_vld_q;
  logic [MAX_ORDER-1:0]     dly_vld_q;
  logic                     cvld_q, dvld_q;
  logic                     out_vld_q;
  logic signed [SAMP_W-1:0] out_sample_q;
  logic                     clipped_q;

  step_t                    step;
  logic [CAW-1:0]           coef_ra;
  logic [DAW-1:0]           dly_ra, dly_wa_a, dly_wa;
  logic signed [SAMP_W-1:0] x;
  logic                     ld, done, out_free;
  logic                     coef_we;
  logic [COEF_W-1:0]        coef_raw;
  logic [DLY_W-1:0]         dly_raw, dly_wd;
  logic                     dly_we;
  logic signed [COEF_W-1:0] coef_m;
  logic signed [DLY_W-1:0]  dly_m;
  logic signed [SAMP_W-1:0] y;
  logic                     clip;
  logic                     order_wr;

  assign order_wr = cfg_we_i && (cfg_idx_i == REG_ORDER);
  assign coef_we  = in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD)
                    && (coef_index_i <= MAX_ORDER);
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q    <= '0;
      xpose_q    <= 1'b0;
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      cvld_q     <= 1'b0;
      dvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (order_wr) begin
        order_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_XPOSE)) begin
        xpose_q <= cfg_data_i[0];
      end
      if (coef_we) begin
        coef_vld_q[CAW'(coef_index_i)] <= 1'b1;
      end
      // an order write drops the whole delay line
      if (order_wr) begin
        dly_vld_q <= '0;
      end else if (dly_we) begin
        dly_vld_q[dly_wa] <= 1'b1;
      end
      cvld_q <= coef_vld_q[coef_ra];
      dvld_q <= dly_vld_q[dly_ra];
      if (ld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_sample_q <= y;
      clipped_q    <= clip;
    end
  end

  fir_dt_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_ORDER + 1)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (CAW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (coef_ra),
    .rdata_o (coef_raw)
  );

  fir_dt_ram #(
    .WIDTH (DLY_W),
    .DEPTH (MAX_ORDER)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_wa),
    .wdata_i (dly_wd),
    .raddr_i (dly_ra),
    .rdata_o (dly_raw)
  );

  // entries never written read as zero
  assign coef_m = cvld_q ? coef_raw : '0;
  assign dly_m  = dvld_q ? dly_raw : '0;

  fir_dt_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .order_i    (order_q),
    .xpose_i    (xpose_q),
    .done_i     (done),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .step_o     (step),
    .coef_ra_o  (coef_ra),
    .dly_ra_o   (dly_ra),
    .dly_wa_o   (dly_wa_a),
    .x_o        (x),
    .ld_o       (ld)
  );

  fir_dt_mac #(
    .MAX_ORDER (MAX_ORDER)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .dly_wa_i (dly_wa_a),
    .x_i      (x),
    .coef_i   (coef_m),
    .dly_i    (dly_m),
    .dly_we_o (dly_we),
    .dly_wa_o (dly_wa),
    .dly_wd_o (dly_wd),
    .done_o   (done),
    .y_o      (y),
    .clip_o   (clip)
  );

  assign out_valid_o  = out_vld_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o    = clipped_q;

endmodule
